/* design/tdp_pkg.sv */
`timescale 1ns / 1ps

package tdp_pkg;

  // Default width of the tested number
  localparam int unsigned NumWidthDefault = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture the candidate, divisor 2, square 4
    logic start_div;  // clear the remainder, point at the top bit
    logic step_div;   // one restoring-division step
    logic next_div;   // advance the divisor and its square
    logic write_out;  // move the verdict into the output register
    logic out_bit;    // verdict to write
  } tdp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cand_le_one;  // incoming candidate is 0 or 1
    logic sq_gt_n;      // divisor squared exceeds the candidate
    logic div_last;     // current division step is the last one
    logic rem_zero;     // remainder is zero
    logic out_free;     // output register can take a verdict this cycle
  } tdp_status_t;

endpackage

/* design/tdp_cand_if.sv */
`timescale 1ns / 1ps

interface tdp_cand_if #(
  parameter int unsigned NumWidth = 16
);
  logic                valid;
  logic                ready;
  logic [NumWidth-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

/* design/tdp_res_if.sv */
`timescale 1ns / 1ps

interface tdp_res_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface

/* design/trial_division_primality_test.sv */
`timescale 1ns / 1ps

// Channel | Direction | Payload
// cand_i  | in        | candidate [NUM_WIDTH-1:0], unsigned
// res_o   | out       | is_prime, 1 bit
//
// Each trial divisor d takes one bound check, NUM_WIDTH restoring-division
// steps in the shared remainder unit and one remainder test; up to 254
// divisors are tried for 16 bits.
// Reset (rst_ni low, asynchronous) returns the controller to idle and empties
// the output register. A stalled result waits in the output register while
// the next candidate is taken; the test stalls only when the result is full.

module trial_division_primality_test import tdp_pkg::*; #(
  parameter int unsigned NUM_WIDTH = NumWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tdp_cand_if.sink    cand_i,
  tdp_res_if.source   res_o
);

  tdp_cmd_t    cmd;
  tdp_status_t status;

  tdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cand_i.valid),
    .in_ready_o (cand_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tdp_datapath #(
    .NumWidth (NUM_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .candidate_i (cand_i.candidate),
    .res_valid_o (res_o.valid),
    .res_prime_o (res_o.is_prime),
    .res_ready_i (res_o.ready)
  );

endmodule

/* design/tdp_datapath.sv */
`timescale 1ns / 1ps

module tdp_datapath import tdp_pkg::*; #(
  parameter int unsigned NumWidth = NumWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tdp_cmd_t            cmd_i,
  output tdp_status_t         status_o,
  input  logic [NumWidth-1:0] candidate_i,
  output logic                res_valid_o,
  output logic                res_prime_o,
  input  logic                res_ready_i
);

  localparam int unsigned DivW = (NumWidth + 1) / 2 + 1;
  localparam int unsigned SqW  = 2 * DivW;
  localparam int unsigned CntW = $clog2(NumWidth);

  logic [NumWidth-1:0] n_q;
  logic [DivW-1:0]     d_q, d_d;
  logic [SqW-1:0]      sq_q, sq_d;
  logic [DivW-1:0]     rem_q, rem_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DivW:0]       trial;
  logic [DivW:0]       trial_sub;
  logic                trial_ge;
  logic                out_valid_q;
  logic                out_prime_q;

  // Shift the next candidate bit into the partial remainder and try to subtract
  assign trial     = {rem_q, n_q[cnt_q]};
  assign trial_ge  = trial >= {1'b0, d_q};
  assign trial_sub = trial - {1'b0, d_q};

  always_comb begin
    d_d   = d_q;
    sq_d  = sq_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      d_d  = DivW'(2);
      sq_d = SqW'(4);
    end
    if (cmd_i.next_div) begin
      // (d+1)^2 = d^2 + 2d + 1
      d_d  = d_q + DivW'(1);
      sq_d = sq_q + SqW'({d_q, 1'b1});
    end
    if (cmd_i.start_div) begin
      rem_d = '0;
      cnt_d = CntW'(NumWidth - 1);
    end
    if (cmd_i.step_div) begin
      rem_d = trial_ge ? trial_sub[DivW-1:0] : trial[DivW-1:0];
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // Hold the working registers; they need no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= candidate_i;
    end
    d_q   <= d_d;
    sq_q  <= sq_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

  // Output register: drop on transfer, load on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write_out) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_out) begin
      out_prime_q <= cmd_i.out_bit;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_prime_o = out_prime_q;

  assign status_o.cand_le_one = (candidate_i >> 1) == '0;
  assign status_o.sq_gt_n     = sq_q > SqW'(n_q);
  assign status_o.div_last    = cnt_q == '0;
  assign status_o.rem_zero    = rem_q == '0;
  assign status_o.out_free    = !out_valid_q || res_ready_i;

  // A verdict never overwrites one still waiting for transfer
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_out |-> (!out_valid_q || res_ready_i))
    else $error("verdict written over a pending result");

  // The square register tracks the divisor
  a_square_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.next_div || cmd_i.load) |=> (sq_q == SqW'(d_q) * SqW'(d_q)))
    else $error("square register out of step with divisor");

  // A division never starts with a divisor below two
  a_divisor_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start_div |-> (d_q >= DivW'(2)))
    else $error("division started with divisor below two");

endmodule

/* design/tdp_ctrl.sv */
`timescale 1ns / 1ps

module tdp_ctrl import tdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tdp_status_t status_i,
  output tdp_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_DIVIDE = 5'b00100,
    ST_TEST   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   prime_q, prime_d;
  logic   accept;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  // Sequence: check square bound, divide bit by bit, test remainder, advance
  always_comb begin
    state_d = state_q;
    prime_d = prime_q;
    cmd_o   = '0;
    cmd_o.out_bit = prime_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (status_i.cand_le_one) begin
            prime_d = 1'b0;
            state_d = ST_FINISH;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (status_i.sq_gt_n) begin
          prime_d = 1'b1;
          state_d = ST_FINISH;
        end else begin
          cmd_o.start_div = 1'b1;
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.step_div = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status_i.rem_zero) begin
          prime_d = 1'b0;
          state_d = ST_FINISH;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.write_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      prime_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prime_q <= prime_d;
    end
  end

  // An accepted item always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted item did not start a test");

  // The last division step is followed by the remainder test
  a_div_to_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE && status_i.div_last) |=> state_q == ST_TEST)
    else $error("division did not end in remainder test");

  // A zero remainder ends the test as composite
  a_zero_rem_composite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TEST && status_i.rem_zero) |=> (state_q == ST_FINISH && !prime_q))
    else $error("exact divisor not reported as composite");

endmodule
